// ----- design/jsu8_pkg.sv -----
`timescale 1ns / 1ps
package jsu8_pkg;

  // Result kinds as seen on the result port
  typedef enum logic [1:0] {
    KIND_UNIT  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // Work handed from the decoder to the result stage
  typedef enum logic [1:0] {
    OP_UNIT  = 2'd0,
    OP_PAIR  = 2'd1,
    OP_ERROR = 2'd2,
    OP_END   = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [20:0] value;
  } op_t;

  // Escape sequence progress
  typedef enum logic [2:0] {
    ESC_NONE  = 3'd0,
    ESC_START = 3'd1,
    ESC_U     = 3'd2,
    ESC_ZERO1 = 3'd3,
    ESC_ZERO2 = 3'd4,
    ESC_HEX1  = 3'd5
  } esc_e;

  localparam logic [7:0]  CH_QUOTE     = 8'h22;
  localparam logic [7:0]  CH_BACKSLASH = 8'h5c;
  localparam logic [7:0]  CH_B         = 8'h62;
  localparam logic [7:0]  CH_F         = 8'h66;
  localparam logic [7:0]  CH_N         = 8'h6e;
  localparam logic [7:0]  CH_R         = 8'h72;
  localparam logic [7:0]  CH_T         = 8'h74;
  localparam logic [7:0]  CH_U         = 8'h75;
  localparam logic [7:0]  CH_ZERO      = 8'h30;
  localparam logic [7:0]  LEAD_E0      = 8'he0;
  localparam logic [7:0]  LEAD_ED      = 8'hed;
  localparam logic [7:0]  LEAD_F0      = 8'hf0;
  localparam logic [7:0]  LEAD_F4      = 8'hf4;
  localparam logic [7:0]  CONT_A0      = 8'ha0;
  localparam logic [7:0]  CONT_90      = 8'h90;
  localparam logic [7:0]  CONT_8F      = 8'h8f;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [15:0] HIGH_BASE    = 16'hd800;
  localparam logic [15:0] LOW_BASE     = 16'hdc00;

endpackage

// ----- design/jsu8_front.sv -----
`timescale 1ns / 1ps
module jsu8_front import jsu8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_string_i,
  output logic       op_valid_o,
  output op_t        op_o
);

  logic [20:0] acc_q, acc_d;
  logic [1:0]  left_q, left_d;
  logic [7:0]  lead_q, lead_d;
  esc_e        esc_q, esc_d;
  logic [3:0]  hex_q, hex_d;
  logic        err_q, err_d;

  // Lower-case hex digit value; bit 4 set when not a digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b0, b[3:0]};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, b[3:0] + 4'd9};
    return r;
  endfunction

  // Decode one byte against the current sequence state
  always_comb begin
    logic       fail;
    logic [4:0] d;
    logic [7:0] b;
    b          = data_byte_i;
    fail       = 1'b0;
    d          = hex_digit(b);
    acc_d      = acc_q;
    left_d     = left_q;
    lead_d     = lead_q;
    esc_d      = esc_q;
    hex_d      = hex_q;
    err_d      = err_q;
    op_valid_o = 1'b0;
    op_o       = '{op: OP_UNIT, value: '0};

    if (end_of_string_i) begin
      op_valid_o = 1'b1;
      op_o.op    = (!err_q && (left_q != 2'd0 || esc_q != ESC_NONE)) ? OP_ERROR : OP_END;
      acc_d      = '0;
      left_d     = '0;
      lead_d     = '0;
      esc_d      = ESC_NONE;
      hex_d      = '0;
      err_d      = 1'b0;
    end else if (err_q) begin
      // drop bytes until the end marker
    end else if (esc_q != ESC_NONE) begin
      case (esc_q)
        ESC_START: begin
          esc_d      = ESC_NONE;
          op_valid_o = 1'b1;
          case (b)
            CH_QUOTE:     op_o.value = 21'h22;
            CH_BACKSLASH: op_o.value = 21'h5c;
            CH_B:         op_o.value = 21'h08;
            CH_F:         op_o.value = 21'h0c;
            CH_N:         op_o.value = 21'h0a;
            CH_R:         op_o.value = 21'h0d;
            CH_T:         op_o.value = 21'h09;
            CH_U: begin
              op_valid_o = 1'b0;
              esc_d      = ESC_U;
            end
            default: fail = 1'b1;
          endcase
        end
        ESC_U, ESC_ZERO1: begin
          if (b != CH_ZERO) fail = 1'b1;
          else esc_d = (esc_q == ESC_U) ? ESC_ZERO1 : ESC_ZERO2;
        end
        ESC_ZERO2: begin
          if (d[4]) fail = 1'b1;
          else begin
            hex_d = d[3:0];
            esc_d = ESC_HEX1;
          end
        end
        default: begin
          if (d[4]) fail = 1'b1;
          else begin
            esc_d      = ESC_NONE;
            hex_d      = '0;
            op_valid_o = 1'b1;
            op_o.value = {13'd0, hex_q, d[3:0]};
          end
        end
      endcase
    end else if (left_q != 2'd0) begin
      if (b[7:6] != 2'b10) fail = 1'b1;
      else if ((lead_q == LEAD_E0 && b < CONT_A0) ||
               (lead_q == LEAD_ED && b >= CONT_A0) ||
               (lead_q == LEAD_F0 && b < CONT_90) ||
               (lead_q == LEAD_F4 && b > CONT_8F)) fail = 1'b1;
      else begin
        lead_d = '0;
        acc_d  = {acc_q[14:0], b[5:0]};
        left_d = left_q - 2'd1;
        if (left_q == 2'd1) begin
          op_valid_o = 1'b1;
          op_o.op    = (acc_d[20:16] == 5'd0) ? OP_UNIT : OP_PAIR;
          op_o.value = acc_d;
        end
      end
    end else if (b == CH_BACKSLASH) begin
      esc_d = ESC_START;
    end else if (!b[7]) begin
      op_valid_o = 1'b1;
      op_o.value = {13'd0, b};
    end else if (b >= 8'hc2 && b <= 8'hdf) begin
      acc_d  = {16'd0, b[4:0]};
      left_d = 2'd1;
      lead_d = b;
    end else if (b >= 8'he0 && b <= 8'hef) begin
      acc_d  = {17'd0, b[3:0]};
      left_d = 2'd2;
      lead_d = b;
    end else if (b >= 8'hf0 && b <= LEAD_F4) begin
      acc_d  = {18'd0, b[2:0]};
      left_d = 2'd3;
      lead_d = b;
    end else begin
      fail = 1'b1;
    end

    // report one error and clear the sequence state
    if (fail) begin
      acc_d      = '0;
      left_d     = '0;
      lead_d     = '0;
      esc_d      = ESC_NONE;
      hex_d      = '0;
      err_d      = 1'b1;
      op_valid_o = 1'b1;
      op_o       = '{op: OP_ERROR, value: '0};
    end
  end

  // Advance state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      left_q <= '0;
      lead_q <= '0;
      esc_q  <= ESC_NONE;
      hex_q  <= '0;
      err_q  <= 1'b0;
    end else if (accept_i) begin
      acc_q  <= acc_d;
      left_q <= left_d;
      lead_q <= lead_d;
      esc_q  <= esc_d;
      hex_q  <= hex_d;
      err_q  <= err_d;
    end
  end

endmodule

// ----- design/jsu8_fifo.sv -----
`timescale 1ns / 1ps
module jsu8_fifo import jsu8_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  rdata_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  op_t           mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      if (do_pop)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

// ----- design/jsu8_back.sv -----
`timescale 1ns / 1ps
module jsu8_back import jsu8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        op_empty_i,
  input  op_t         op_i,
  output logic        op_pop_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [15:0] code_unit_o,
  output logic [1:0]  kind_o,
  output logic        last_o
);

  logic        valid_q;
  logic [15:0] unit_q;
  kind_e       kind_q;
  logic        last_q;
  logic        pend_q;
  logic [15:0] low_q;
  logic        out_free;
  logic [20:0] offs;

  assign out_free = !valid_q || pop_i;
  assign op_pop_o = out_free && !pend_q && !op_empty_i;
  assign offs     = op_i.value - SUPP_BASE;

  // Control of the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (out_free) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else begin
        valid_q <= !op_empty_i;
        pend_q  <= !op_empty_i && (op_i.op == OP_PAIR);
      end
    end
  end

  // Load the result payload; split a supplementary point into two units
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_q) begin
        unit_q <= low_q;
        kind_q <= KIND_UNIT;
        last_q <= 1'b1;
      end else if (!op_empty_i) begin
        low_q <= LOW_BASE + {6'd0, offs[9:0]};
        case (op_i.op)
          OP_UNIT: begin
            unit_q <= op_i.value[15:0];
            kind_q <= KIND_UNIT;
            last_q <= 1'b1;
          end
          OP_PAIR: begin
            unit_q <= HIGH_BASE + {6'd0, offs[19:10]};
            kind_q <= KIND_UNIT;
            last_q <= 1'b0;
          end
          OP_ERROR: begin
            unit_q <= '0;
            kind_q <= KIND_ERROR;
            last_q <= 1'b1;
          end
          default: begin
            unit_q <= '0;
            kind_q <= KIND_END;
            last_q <= 1'b1;
          end
        endcase
      end
    end
  end

  assign empty_o     = !valid_q;
  assign code_unit_o = unit_q;
  assign kind_o      = kind_q;
  assign last_o      = last_q;

endmodule

// ----- design/json_string_utf8_to_utf16_top.sv -----
`timescale 1ns / 1ps
// JSON string body transcoder: one UTF-8 byte (or an end marker) per input
// transfer, UTF-16 code units, error and end results out. A new byte is
// taken every cycle while the internal op queue (QueueDepth entries) has
// room; the decoder finishes each byte in the cycle it is taken. Results
// leave through a one-entry output register at one per cycle while pop is
// held and work is queued, so a supplementary code point yields two results
// in a row (high then low surrogate); all other items produce at most one
// result. A result passes through an op queue entry, then the output register.
module json_string_utf8_to_utf16_top import jsu8_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_string_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit_o,
  output logic [1:0]  kind_o,
  output logic        last_o
);

  logic accept;
  logic op_valid;
  op_t  op_in;
  op_t  op_out;
  logic op_empty;
  logic op_pop;

  assign accept = push && !full;

  jsu8_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_string_i (end_of_string_i),
    .op_valid_o      (op_valid),
    .op_o            (op_in)
  );

  jsu8_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && op_valid),
    .wdata_i (op_in),
    .full_o  (full),
    .pop_i   (op_pop),
    .empty_o (op_empty),
    .rdata_o (op_out)
  );

  jsu8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_empty_i  (op_empty),
    .op_i        (op_out),
    .op_pop_o    (op_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .code_unit_o (code_unit_o),
    .kind_o      (kind_o),
    .last_o      (last_o)
  );

`ifndef ASSERT_OFF
  // Error and end results carry a zero code unit
  a_nonunit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_UNIT) |-> (code_unit_o == 16'd0))
    else $error("non-unit result with nonzero code unit");

  // A result that is not last is a high surrogate
  a_high_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_o) |-> (kind_o == KIND_UNIT && code_unit_o[15:10] == 6'b110110))
    else $error("non-final result is not a high surrogate");

  // A high surrogate transfer is followed by its low surrogate
  a_low_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_o) |=>
      (!empty && last_o && kind_o == KIND_UNIT && code_unit_o[15:10] == 6'b110111))
    else $error("low surrogate missing after high surrogate");
`endif

endmodule

// ----- verif/tb_json_string_utf8_to_utf16_top.sv -----
`timescale 1ns / 1ps
module tb_json_string_utf8_to_utf16_top import jsu8_pkg::*;;

  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          ITEMS_PER_PHASE = 250;
  localparam int          TAIL_CYCLES = 12;
  localparam logic [7:0]  CH_NINE = 8'h39;
  localparam logic [7:0]  CH_A_LOWER = 8'h61;
  localparam logic [7:0]  LEAD_C2 = 8'hc2;
  localparam logic [7:0]  LEAD_DF = 8'hdf;
  localparam logic [7:0]  LEAD_EF = 8'hef;
  localparam logic [7:0]  ASCII_MAX = 8'h7f;

  typedef struct {
    logic [7:0] data;
    logic       eos;
  } byte_item_t;

  typedef struct {
    logic [15:0] code_unit;
    kind_e       kind;
    logic        last;
  } utf16_result_t;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = 8'h00;
  logic        end_of_string_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] code_unit_o;
  logic [1:0]  kind_o;
  logic        last_o;

  json_string_utf8_to_utf16_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte_i),
    .end_of_string_i (end_of_string_i),
    .empty           (empty),
    .pop             (pop),
    .code_unit_o     (code_unit_o),
    .kind_o          (kind_o),
    .last_o          (last_o)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_item_t    byte_feed_q[$];
  utf16_result_t units_due[$];

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int hold_id = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int queued_items = 0;
  int bytes_sent = 0;
  int units_seen = 0;
  int pairs_seen = 0;
  int malformed_seen = 0;
  int ends_seen = 0;
  int fail_cnt = 0;
  int idle_cycles = 0;
  logic took_item = 1'b0;

  // Decoder state of the predictor
  logic [20:0] cp_bits = '0;
  logic [1:0]  cont_due = '0;
  logic [7:0]  lead_byte = '0;
  esc_e        esc_state = ESC_NONE;
  logic [7:0]  hex_high = '0;
  logic        err_reported = 1'b0;

  function automatic void add_result(input logic [15:0] cu, input kind_e k, input logic lst);
    utf16_result_t r;
    r.code_unit = cu;
    r.kind = k;
    r.last = lst;
    units_due.push_back(r);
  endfunction

  function automatic void clear_decoder();
    cp_bits = '0;
    cont_due = '0;
    lead_byte = '0;
    esc_state = ESC_NONE;
    hex_high = '0;
  endfunction

  // Report malformed input once and drop everything up to the end marker
  function automatic void decode_fail();
    clear_decoder();
    err_reported = 1'b1;
    add_result(16'h0000, KIND_ERROR, 1'b1);
  endfunction

  // Bit 4 set means the byte is not a lower-case hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return {1'b0, 4'(b - CH_ZERO)};
    if (b >= CH_A_LOWER && b <= CH_F) return {1'b0, 4'(b - CH_A_LOWER + 8'd10)};
    return 5'h10;
  endfunction

  function automatic void emit_code_point(input logic [20:0] cp);
    logic [20:0] off;
    off = cp - SUPP_BASE;
    if (cp <= 21'h00ffff) begin
      add_result(cp[15:0], KIND_UNIT, 1'b1);
    end else begin
      add_result(HIGH_BASE + {6'd0, off[19:10]}, KIND_UNIT, 1'b0);
      add_result(LOW_BASE + {6'd0, off[9:0]}, KIND_UNIT, 1'b1);
    end
  endfunction

  function automatic void decode_escape(input logic [7:0] b);
    logic [4:0] hv;
    hv = hex_value(b);
    case (esc_state)
      ESC_START: begin
        esc_state = ESC_NONE;
        case (b)
          CH_QUOTE:     add_result(16'h0022, KIND_UNIT, 1'b1);
          CH_BACKSLASH: add_result(16'h005c, KIND_UNIT, 1'b1);
          CH_B:         add_result(16'h0008, KIND_UNIT, 1'b1);
          CH_F:         add_result(16'h000c, KIND_UNIT, 1'b1);
          CH_N:         add_result(16'h000a, KIND_UNIT, 1'b1);
          CH_R:         add_result(16'h000d, KIND_UNIT, 1'b1);
          CH_T:         add_result(16'h0009, KIND_UNIT, 1'b1);
          CH_U:         esc_state = ESC_U;
          default:      decode_fail();
        endcase
      end
      ESC_U, ESC_ZERO1: begin
        if (b != CH_ZERO) decode_fail();
        else esc_state = (esc_state == ESC_U) ? ESC_ZERO1 : ESC_ZERO2;
      end
      ESC_ZERO2: begin
        if (hv[4]) begin
          decode_fail();
        end else begin
          hex_high = {4'd0, hv[3:0]};
          esc_state = ESC_HEX1;
        end
      end
      default: begin
        if (hv[4]) begin
          decode_fail();
        end else begin
          esc_state = ESC_NONE;
          add_result({8'd0, hex_high[3:0], hv[3:0]}, KIND_UNIT, 1'b1);
          hex_high = '0;
        end
      end
    endcase
  endfunction

  function automatic void decode_plain_byte(input logic [7:0] b);
    if (cont_due != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        decode_fail();
      end else if ((lead_byte == LEAD_E0 && b < CONT_A0) ||
                   (lead_byte == LEAD_ED && b >= CONT_A0) ||
                   (lead_byte == LEAD_F0 && b < CONT_90) ||
                   (lead_byte == LEAD_F4 && b > CONT_8F)) begin
        decode_fail();
      end else begin
        lead_byte = '0;
        cp_bits = {cp_bits[14:0], b[5:0]};
        cont_due = cont_due - 2'd1;
        if (cont_due == 2'd0) emit_code_point(cp_bits);
      end
    end else if (b == CH_BACKSLASH) begin
      esc_state = ESC_START;
    end else if (b <= ASCII_MAX) begin
      add_result({8'd0, b}, KIND_UNIT, 1'b1);
    end else if (b >= LEAD_C2 && b <= LEAD_DF) begin
      cp_bits = {16'd0, b[4:0]};
      cont_due = 2'd1;
      lead_byte = b;
    end else if (b >= LEAD_E0 && b <= LEAD_EF) begin
      cp_bits = {17'd0, b[3:0]};
      cont_due = 2'd2;
      lead_byte = b;
    end else if (b >= LEAD_F0 && b <= LEAD_F4) begin
      cp_bits = {18'd0, b[2:0]};
      cont_due = 2'd3;
      lead_byte = b;
    end else begin
      decode_fail();
    end
  endfunction

  // Work out the results of one accepted byte or end marker
  function automatic void transcode_item(input logic [7:0] b, input logic eos);
    if (eos) begin
      if (!err_reported && (cont_due != 2'd0 || esc_state != ESC_NONE))
        add_result(16'h0000, KIND_ERROR, 1'b1);
      else
        add_result(16'h0000, KIND_END, 1'b1);
      clear_decoder();
      err_reported = 1'b0;
    end else if (!err_reported) begin
      if (esc_state != ESC_NONE) decode_escape(b);
      else decode_plain_byte(b);
    end
  endfunction

  function automatic void check_result();
    utf16_result_t want;
    if (units_due.size() == 0) begin
      $error("unexpected result: code_unit %h kind %0d last %0b", code_unit_o, kind_o, last_o);
      fail_cnt++;
      return;
    end
    want = units_due.pop_front();
    if (code_unit_o !== want.code_unit) begin
      $error("code_unit mismatch: expected %h, actual %h", want.code_unit, code_unit_o);
      fail_cnt++;
    end
    if (kind_o !== want.kind) begin
      $error("kind mismatch: expected %0d, actual %0d", want.kind, kind_o);
      fail_cnt++;
    end
    if (last_o !== want.last) begin
      $error("last mismatch: expected %0b, actual %0b", want.last, last_o);
      fail_cnt++;
    end
    case (want.kind)
      KIND_UNIT: begin
        units_seen++;
        if (!want.last) pairs_seen++;
      end
      KIND_ERROR: malformed_seen++;
      default:    ends_seen++;
    endcase
  endfunction

  // Sample transfers on both sides and run the watchdog
  always @(posedge clk) begin
    took_item <= rst_ni && push && !full;
    if (rst_ni) begin
      if (push && !full) begin
        transcode_item(data_byte_i, end_of_string_i);
        bytes_sent++;
      end
      if (pop && !empty) check_result();
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[json_string_utf8_to_utf16_top] ERROR");
        $finish;
      end
    end
  end

  // Offer items from the feed queue; hold an offer until it is taken
  always @(negedge clk) begin
    if (took_item) void'(byte_feed_q.pop_front());
    if (push && !took_item) begin
      push <= 1'b1;
    end else if (rst_ni && byte_feed_q.size() != 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      push <= 1'b1;
      data_byte_i <= byte_feed_q[0].data;
      end_of_string_i <= byte_feed_q[0].eos;
    end else begin
      push <= 1'b0;
    end
  end

  // Drain results, with random stalls and a single long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_id) begin
      hold_seen = hold_id;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end
  end

  function automatic void add_byte(input logic [7:0] b);
    byte_item_t it;
    it.data = b;
    it.eos = 1'b0;
    byte_feed_q.push_back(it);
    queued_items++;
  endfunction

  // The data byte of an end marker is ignored, so randomize it
  function automatic void add_end();
    byte_item_t it;
    it.data = 8'($urandom_range(0, 255));
    it.eos = 1'b1;
    byte_feed_q.push_back(it);
    queued_items++;
  endfunction

  function automatic logic [7:0] hex_char();
    int d;
    d = $urandom_range(0, 15);
    return (d < 10) ? 8'(CH_ZERO + d) : 8'(CH_A_LOWER + d - 10);
  endfunction

  function automatic void add_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  // One piece of string content: mostly well formed, some noise and breakage
  function automatic void add_token();
    int          pick;
    int          k;
    logic [7:0]  b;
    logic [20:0] cp;
    logic [7:0]  esc_chars [7];
    logic [7:0]  leads [7];
    esc_chars = '{CH_QUOTE, CH_BACKSLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    leads = '{LEAD_C2, LEAD_DF, LEAD_E0, LEAD_ED, LEAD_EF, LEAD_F0, LEAD_F4};
    pick = $urandom_range(0, 99);
    if (pick < 34) begin
      b = 8'($urandom_range(0, 127));
      if (b == CH_BACKSLASH) b = CH_ZERO;
      add_byte(b);
    end else if (pick < 48) begin
      add_code_point(21'($urandom_range(21'h80, 21'h7ff)));
    end else if (pick < 62) begin
      case ($urandom_range(0, 7))
        0:       cp = 21'h800;
        1:       cp = 21'hd7ff;
        2:       cp = 21'he000;
        3:       cp = 21'hffff;
        default: cp = 21'($urandom_range(21'h800, 21'hffff));
      endcase
      // steer clear of the surrogate range
      if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h1000;
      add_code_point(cp);
    end else if (pick < 70) begin
      case ($urandom_range(0, 3))
        0:       cp = 21'h10000;
        1:       cp = 21'h10ffff;
        default: cp = 21'($urandom_range(21'h10000, 21'h10ffff));
      endcase
      add_code_point(cp);
    end else if (pick < 78) begin
      add_byte(CH_BACKSLASH);
      add_byte(esc_chars[$urandom_range(0, 6)]);
    end else if (pick < 84) begin
      add_byte(CH_BACKSLASH);
      add_byte(CH_U);
      add_byte(CH_ZERO);
      add_byte(CH_ZERO);
      add_byte(hex_char());
      add_byte(hex_char());
    end else if (pick < 89) begin
      add_byte(8'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      // truncated or out-of-range multibyte sequence
      b = leads[$urandom_range(0, 6)];
      k = (b >= LEAD_F0) ? 3 : (b >= LEAD_E0) ? 2 : 1;
      add_byte(b);
      repeat ($urandom_range(0, k - 1)) add_byte(8'($urandom_range(8'h80, 8'hbf)));
      if ($urandom_range(0, 1)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      // escape cut short or broken
      k = $urandom_range(0, 4);
      add_byte(CH_BACKSLASH);
      if (k >= 1) add_byte(CH_U);
      if (k >= 2) add_byte(CH_ZERO);
      if (k >= 3) add_byte(CH_ZERO);
      if (k >= 4) add_byte(hex_char());
      if ($urandom_range(0, 1)) add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void add_random_string();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 12)) add_token();
    end
    add_end();
  endfunction

  // Wait until every queued item went in and every result came out
  task automatic wait_drained();
    do @(negedge clk);
    while (byte_feed_q.size() != 0 || push || units_due.size() != 0);
  endtask

  initial begin
    int send_pct [4];
    int stall_pct [4];
    send_pct = '{0, 68, 0, 30};
    stall_pct = '{0, 0, 68, 30};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // Directed: ASCII extremes, supplementary extremes, hex escape,
    // newline escape, bad lead then ignored byte, encoded surrogate,
    // sequence cut off by the end marker
    add_byte(8'h00);
    add_byte(ASCII_MAX);
    add_code_point(21'h10000);
    add_code_point(21'h10ffff);
    add_byte(CH_BACKSLASH);
    add_byte(CH_U);
    add_byte(CH_ZERO);
    add_byte(CH_ZERO);
    add_byte(CH_F);
    add_byte(CH_F);
    add_byte(CH_BACKSLASH);
    add_byte(CH_N);
    add_byte(8'hff);
    add_byte(8'h41);
    add_end();
    add_byte(LEAD_ED);
    add_byte(CONT_A0);
    add_end();
    add_byte(LEAD_E0);
    add_end();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pct[ph];
      pop_stall_pct = stall_pct[ph];
      // back up the output while the sender keeps offering
      if (ph == 0) hold_id++;
      queued_items = 0;
      while (queued_items < ITEMS_PER_PHASE) add_random_string();
      wait_drained();
    end

    pop_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d bytes and end markers across four idle/stall mixes plus a long hold-off.",
             bytes_sent);
    $display("Checked %0d code units (%0d surrogate pairs), %0d malformed, %0d end results.",
             units_seen, pairs_seen, malformed_seen, ends_seen);
    if (fail_cnt == 0 && units_due.size() == 0) begin
      $display("[json_string_utf8_to_utf16_top] OK");
    end else begin
      $display("[json_string_utf8_to_utf16_top] ERROR");
    end
    $finish;
  end

endmodule
